/* rtl/rvx_pkg.sv */
// ----------------------------------------------------------------------------
// rvx_pkg
// Shared types and encodings of the RV32I subset executor.
// ----------------------------------------------------------------------------
package rvx_pkg;

    // major opcodes
    localparam logic [6:0] FUNC_REG    = 7'h33;
    localparam logic [6:0] FUNC_IMM    = 7'h13;
    localparam logic [6:0] FUNC_LOAD   = 7'h03;
    localparam logic [6:0] FUNC_STORE  = 7'h23;
    localparam logic [6:0] FUNC_BRANCH = 7'h63;
    localparam logic [6:0] FUNC_JAL    = 7'h6F;

    localparam logic [6:0] VARIANT_SUB = 7'h20;

    // funct3 codes
    localparam logic [2:0] MINOR_ADD  = 3'h0;
    localparam logic [2:0] MINOR_AND  = 3'h7;
    localparam logic [2:0] MINOR_OR   = 3'h6;
    localparam logic [2:0] MINOR_XOR  = 3'h4;
    localparam logic [2:0] MINOR_WORD = 3'h2;
    localparam logic [2:0] MINOR_BEQ  = 3'h0;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_UNSUP    = 2'd1,
        ST_MISALIGN = 2'd2,
        ST_RANGE    = 2'd3
    } status_t;

    typedef struct packed {
        logic [6:0]         func;
        logic [2:0]         minor_op;
        logic [6:0]         variant;
        logic [4:0]         dest_index;
        logic [4:0]         src_a_index;
        logic [4:0]         src_b_index;
        logic signed [31:0] immediate;
    } cmd_t;

    typedef struct packed {
        logic [31:0] next_pc;
        logic        reg_write;
        logic [4:0]  write_reg;
        logic [31:0] write_value;
        status_t     status;
    } rsp_t;

endpackage

/* rtl/rvx_if.sv */
// ----------------------------------------------------------------------------
// rvx_cmd_if / rvx_rsp_if
// Valid/ready channels carrying an instruction item and a result item.
// ----------------------------------------------------------------------------
interface rvx_cmd_if;
    logic          valid;
    logic          ready;
    rvx_pkg::cmd_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface rvx_rsp_if;
    logic          valid;
    logic          ready;
    rvx_pkg::rsp_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* rtl/rvx_ram.sv */
// ----------------------------------------------------------------------------
// rvx_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module rvx_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                                        clk,
    input  logic                                        we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                            wdata,
    input  logic                                        re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                            rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/rv32i_subset_executor.sv */
// ----------------------------------------------------------------------------
// rv32i_subset_executor
// Executes decoded ADD/SUB/AND/OR/XOR/ADDI/LW/SW/BEQ/JAL instructions against
// a register file, a program counter and a word-addressed data memory.
// ----------------------------------------------------------------------------
//  port   | dir | kind          | carries
//  cmd    | in  | valid/ready   | one decoded instruction item
//  rsp    | out | valid/ready   | next PC, register write, status
//  APB    | in  | psel/penable  | start_pc at byte address 0
//
// One item per cycle sustained while rsp is ready; each accepted item passes the register
// file read, then execute with the data memory read landing in the result stage.
// After reset the data memory is zeroed word by word, with cmd.ready held low.
// The register file commits when a result is taken; pending writes are forwarded.
// A stalled rsp holds the result stage and backs up into cmd.ready.
// ----------------------------------------------------------------------------
module rv32i_subset_executor #(
    parameter int DMEM_WORDS = 1024
) (
    input  logic             clk,
    input  logic             rst_n,
    rvx_cmd_if.sink          cmd,
    rvx_rsp_if.source        rsp,
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [2:0]       paddr,
    input  logic [31:0]      pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam int         AW           = (DMEM_WORDS > 1) ? $clog2(DMEM_WORDS) : 1;
    localparam logic       REG_START_PC = 1'b0;
    localparam logic [AW-1:0] CLR_LAST  = AW'(DMEM_WORDS - 1);

    // configuration
    logic [31:0] start_pc_reg;
    logic        cfg_wr;

    // clearing pass
    logic          clear_busy_reg;
    logic [AW-1:0] clr_cnt_reg;

    // pipeline
    logic          cmd_fire, rsp_fire, s1_adv;
    logic          s1_valid_reg;
    rvx_pkg::cmd_t s1_cmd_reg;
    logic          s1_a_known_reg, s1_b_known_reg;
    logic [31:0]   pc_reg;

    logic             s2_valid_reg;
    logic [31:0]      s2_npc_reg;
    logic             s2_wr_reg;
    logic [4:0]       s2_rd_reg;
    logic [31:0]      s2_val_reg;
    logic             s2_load_reg;
    rvx_pkg::status_t s2_status_reg;

    // last committed register write
    logic        wb_valid_reg;
    logic [4:0]  wb_rd_reg;
    logic [31:0] wb_val_reg;

    logic [31:0] rf_valid_reg;
    logic [31:0] rf_a_rdata, rf_b_rdata, dm_rdata;
    logic        rf_we;
    logic [31:0] res_value;

    // execute
    logic [31:0]      op_a, op_b, addr, pc_plus4, npc, val;
    logic             wr, is_load, is_store;
    rvx_pkg::status_t status, chk;
    logic [AW-1:0]    dm_idx;

    logic          dm_we, dm_re;
    logic [AW-1:0] dm_waddr;
    logic [31:0]   dm_wdata;

    assign cmd_fire = cmd.valid && cmd.ready;
    assign rsp_fire = rsp.valid && rsp.ready;
    assign s1_adv   = s1_valid_reg && (!s2_valid_reg || rsp_fire);
    assign cmd.ready = !clear_busy_reg && (!s1_valid_reg || s1_adv);

    // APB
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_START_PC);
    assign prdata = (paddr[2] == REG_START_PC) ? start_pc_reg : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_pc_reg <= 32'd0;
        end
        else if (cfg_wr)
        begin
            start_pc_reg <= pwdata;
        end
    end

    // data memory clearing pass
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_busy_reg <= 1'b1;
            clr_cnt_reg    <= '0;
        end
        else if (clear_busy_reg)
        begin
            clr_cnt_reg <= clr_cnt_reg + AW'(1);
            if (clr_cnt_reg == CLR_LAST)
            begin
                clear_busy_reg <= 1'b0;
            end
        end
    end

    // register file: two copies for two read ports
    assign res_value = s2_load_reg ? dm_rdata : s2_val_reg;
    assign rf_we     = rsp_fire && s2_wr_reg;

    rvx_ram #(.WIDTH(32), .DEPTH(32)) u_rf_a (
        .clk   (clk),
        .we    (rf_we),
        .waddr (s2_rd_reg),
        .wdata (res_value),
        .re    (cmd_fire),
        .raddr (cmd.data.src_a_index),
        .rdata (rf_a_rdata)
    );

    rvx_ram #(.WIDTH(32), .DEPTH(32)) u_rf_b (
        .clk   (clk),
        .we    (rf_we),
        .waddr (s2_rd_reg),
        .wdata (res_value),
        .re    (cmd_fire),
        .raddr (cmd.data.src_b_index),
        .rdata (rf_b_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rf_valid_reg <= '0;
            wb_valid_reg <= 1'b0;
        end
        else if (rf_we)
        begin
            rf_valid_reg[s2_rd_reg] <= 1'b1;
            wb_valid_reg            <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rf_we)
        begin
            wb_rd_reg  <= s2_rd_reg;
            wb_val_reg <= res_value;
        end
    end

    // stage 1 capture
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (cmd_fire)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_fire)
        begin
            s1_cmd_reg     <= cmd.data;
            // an entry never written reads as zero
            s1_a_known_reg <= rf_valid_reg[cmd.data.src_a_index];
            s1_b_known_reg <= rf_valid_reg[cmd.data.src_b_index];
        end
    end

    // operand forwarding: pending result first, then last commit, then RAM
    always_comb
    begin
        op_a = s1_a_known_reg ? rf_a_rdata : 32'd0;
        if (wb_valid_reg && wb_rd_reg == s1_cmd_reg.src_a_index)
        begin
            op_a = wb_val_reg;
        end
        if (s2_valid_reg && s2_wr_reg && s2_rd_reg == s1_cmd_reg.src_a_index)
        begin
            op_a = res_value;
        end
        op_b = s1_b_known_reg ? rf_b_rdata : 32'd0;
        if (wb_valid_reg && wb_rd_reg == s1_cmd_reg.src_b_index)
        begin
            op_b = wb_val_reg;
        end
        if (s2_valid_reg && s2_wr_reg && s2_rd_reg == s1_cmd_reg.src_b_index)
        begin
            op_b = res_value;
        end
    end

    // execute
    assign pc_plus4 = pc_reg + 32'd4;
    assign addr     = op_a + unsigned'(s1_cmd_reg.immediate);
    assign dm_idx   = addr[AW+1:2];

    always_comb
    begin
        if (addr[1:0] != 2'b00)
        begin
            chk = rvx_pkg::ST_MISALIGN;
        end
        else if (addr[31:2] >= 30'(DMEM_WORDS))
        begin
            chk = rvx_pkg::ST_RANGE;
        end
        else
        begin
            chk = rvx_pkg::ST_OK;
        end
    end

    always_comb
    begin
        npc      = pc_plus4;
        val      = 32'd0;
        wr       = 1'b0;
        is_load  = 1'b0;
        is_store = 1'b0;
        status   = rvx_pkg::ST_OK;
        case (s1_cmd_reg.func)
            rvx_pkg::FUNC_REG:
            begin
                wr = 1'b1;
                case (s1_cmd_reg.minor_op)
                    rvx_pkg::MINOR_ADD:
                        val = (s1_cmd_reg.variant == rvx_pkg::VARIANT_SUB) ? op_a - op_b
                                                                          : op_a + op_b;
                    rvx_pkg::MINOR_AND: val = op_a & op_b;
                    rvx_pkg::MINOR_OR:  val = op_a | op_b;
                    rvx_pkg::MINOR_XOR: val = op_a ^ op_b;
                    default:
                    begin
                        wr     = 1'b0;
                        status = rvx_pkg::ST_UNSUP;
                    end
                endcase
            end
            rvx_pkg::FUNC_IMM:
            begin
                if (s1_cmd_reg.minor_op == rvx_pkg::MINOR_ADD)
                begin
                    wr  = 1'b1;
                    val = addr;
                end
                else
                begin
                    status = rvx_pkg::ST_UNSUP;
                end
            end
            rvx_pkg::FUNC_LOAD:
            begin
                if (s1_cmd_reg.minor_op == rvx_pkg::MINOR_WORD)
                begin
                    status = chk;
                    if (chk == rvx_pkg::ST_OK)
                    begin
                        wr      = 1'b1;
                        is_load = 1'b1;
                    end
                end
                else
                begin
                    status = rvx_pkg::ST_UNSUP;
                end
            end
            rvx_pkg::FUNC_STORE:
            begin
                if (s1_cmd_reg.minor_op == rvx_pkg::MINOR_WORD)
                begin
                    status   = chk;
                    is_store = (chk == rvx_pkg::ST_OK);
                end
                else
                begin
                    status = rvx_pkg::ST_UNSUP;
                end
            end
            rvx_pkg::FUNC_BRANCH:
            begin
                if (s1_cmd_reg.minor_op == rvx_pkg::MINOR_BEQ)
                begin
                    if (op_a == op_b)
                    begin
                        npc = pc_reg + unsigned'(s1_cmd_reg.immediate);
                    end
                end
                else
                begin
                    status = rvx_pkg::ST_UNSUP;
                end
            end
            rvx_pkg::FUNC_JAL:
            begin
                wr  = 1'b1;
                val = pc_plus4;
                npc = pc_reg + unsigned'(s1_cmd_reg.immediate);
            end
            default:
            begin
                status = rvx_pkg::ST_UNSUP;
            end
        endcase
        // x0 discards the write
        if (s1_cmd_reg.dest_index == 5'd0)
        begin
            wr      = 1'b0;
            is_load = 1'b0;
            val     = 32'd0;
        end
    end

    // program counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= 32'd0;
        end
        else if (cfg_wr)
        begin
            pc_reg <= pwdata;
        end
        else if (s1_adv)
        begin
            pc_reg <= npc;
        end
    end

    // data memory: stores commit as they leave execute
    assign dm_we    = clear_busy_reg || (s1_adv && is_store);
    assign dm_waddr = clear_busy_reg ? clr_cnt_reg : dm_idx;
    assign dm_wdata = clear_busy_reg ? 32'd0 : op_b;
    assign dm_re    = s1_adv && is_load;

    rvx_ram #(.WIDTH(32), .DEPTH(DMEM_WORDS)) u_dmem (
        .clk   (clk),
        .we    (dm_we),
        .waddr (dm_waddr),
        .wdata (dm_wdata),
        .re    (dm_re),
        .raddr (dm_idx),
        .rdata (dm_rdata)
    );

    // result stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (s1_adv)
        begin
            s2_valid_reg <= 1'b1;
        end
        else if (rsp_fire)
        begin
            s2_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            s2_npc_reg    <= npc;
            s2_wr_reg     <= wr;
            s2_rd_reg     <= wr ? s1_cmd_reg.dest_index : 5'd0;
            s2_val_reg    <= val;
            s2_load_reg   <= is_load;
            s2_status_reg <= status;
        end
    end

    assign rsp.valid = s2_valid_reg;

    always_comb
    begin
        rsp.data.next_pc     = s2_npc_reg;
        rsp.data.reg_write   = s2_wr_reg;
        rsp.data.write_reg   = s2_rd_reg;
        rsp.data.write_value = res_value;
        rsp.data.status      = s2_status_reg;
    end

    // checks
    a_no_accept_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        clear_busy_reg |-> !cmd.ready)
        else $error("item accepted during data memory clear");

    a_no_x0_write: assert property (@(posedge clk) disable iff (!rst_n)
        rf_we |-> (s2_rd_reg != 5'd0))
        else $error("register file write to x0");

    a_s1_adv_room: assert property (@(posedge clk) disable iff (!rst_n)
        s1_adv |-> (!s2_valid_reg || rsp_fire))
        else $error("execute stage advanced into a full result stage");

    a_wb_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rf_we |=> (wb_valid_reg && wb_rd_reg == $past(s2_rd_reg)))
        else $error("committed write not held for forwarding");

    a_store_not_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_adv && is_store) |-> !clear_busy_reg)
        else $error("store during data memory clear");

endmodule

/* tb/rvx_result_checker.sv */
// ----------------------------------------------------------------------------
// rvx_result_checker
// Watches the instruction and result channels and the APB port of the
// executor. Each accepted instruction item is run through a local copy of
// the register file, PC and data memory; each accepted result item is
// compared field by field against the oldest predicted result.
// ----------------------------------------------------------------------------
module rvx_result_checker
    import rvx_pkg::*;
#(
    parameter int         DMEM_WORDS    = 1024,
    parameter logic [2:0] START_PC_ADDR = 3'd0
) (
    input  logic        clk,
    input  logic        rst_n,
    rvx_cmd_if          cmd,
    rvx_rsp_if          rsp,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    output int          mismatches,
    output int          pending
);

    logic [31:0] start_pc_q;
    logic [31:0] pc_q;
    logic [31:0] gpr [32];
    logic [31:0] dmem [DMEM_WORDS];

    rsp_t expected_results [$];
    rsp_t want;

    function automatic status_t addr_status(logic [31:0] addr);
        if (addr[1:0] != 2'b00)
            return ST_MISALIGN;
        if (addr[31:2] >= DMEM_WORDS)
            return ST_RANGE;
        return ST_OK;
    endfunction

    // Executes one instruction against the local architectural state.
    function automatic rsp_t exec_instr(cmd_t c);
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] imm;
        logic [31:0] npc;
        logic [31:0] val;
        logic [31:0] addr;
        logic        wr;
        status_t     st;
        rsp_t        r;
        a   = (c.src_a_index == 5'd0) ? 32'd0 : gpr[c.src_a_index];
        b   = (c.src_b_index == 5'd0) ? 32'd0 : gpr[c.src_b_index];
        imm = c.immediate;
        npc = pc_q + 32'd4;
        val = 32'd0;
        wr  = 1'b0;
        st  = ST_OK;
        case (c.func)
            FUNC_REG:
            begin
                wr = 1'b1;
                case (c.minor_op)
                    MINOR_ADD: val = (c.variant == VARIANT_SUB) ? a - b : a + b;
                    MINOR_AND: val = a & b;
                    MINOR_OR:  val = a | b;
                    MINOR_XOR: val = a ^ b;
                    default:
                    begin
                        wr = 1'b0;
                        st = ST_UNSUP;
                    end
                endcase
            end
            FUNC_IMM:
            begin
                if (c.minor_op == MINOR_ADD)
                begin
                    wr  = 1'b1;
                    val = a + imm;
                end
                else
                    st = ST_UNSUP;
            end
            FUNC_LOAD:
            begin
                if (c.minor_op == MINOR_WORD)
                begin
                    addr = a + imm;
                    st   = addr_status(addr);
                    if (st == ST_OK)
                    begin
                        wr  = 1'b1;
                        val = dmem[int'(addr[31:2])];
                    end
                end
                else
                    st = ST_UNSUP;
            end
            FUNC_STORE:
            begin
                if (c.minor_op == MINOR_WORD)
                begin
                    addr = a + imm;
                    st   = addr_status(addr);
                    if (st == ST_OK)
                        dmem[int'(addr[31:2])] = b;
                end
                else
                    st = ST_UNSUP;
            end
            FUNC_BRANCH:
            begin
                if (c.minor_op == MINOR_BEQ)
                begin
                    if (a == b)
                        npc = pc_q + imm;
                end
                else
                    st = ST_UNSUP;
            end
            FUNC_JAL:
            begin
                wr  = 1'b1;
                val = pc_q + 32'd4;
                npc = pc_q + imm;
            end
            default: st = ST_UNSUP;
        endcase

        // x0 swallows the write entirely
        if (wr && c.dest_index != 5'd0)
            gpr[c.dest_index] = val;
        else
        begin
            wr  = 1'b0;
            val = 32'd0;
        end
        pc_q = npc;

        r.next_pc     = npc;
        r.reg_write   = wr;
        r.write_reg   = wr ? c.dest_index : 5'd0;
        r.write_value = val;
        r.status      = st;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_pc_q = 32'd0;
            pc_q       = 32'd0;
            for (int i = 0; i < 32; i++)
                gpr[i] = 32'd0;
            for (int i = 0; i < DMEM_WORDS; i++)
                dmem[i] = 32'd0;
            expected_results.delete();
            mismatches = 0;
            pending    = 0;
        end
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("result item with nothing outstanding: next_pc %h",
                           rsp.data.next_pc);
                    mismatches++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (rsp.data.next_pc !== want.next_pc)
                    begin
                        $error("next_pc: expected %h, got %h",
                               want.next_pc, rsp.data.next_pc);
                        mismatches++;
                    end
                    if (rsp.data.reg_write !== want.reg_write)
                    begin
                        $error("reg_write: expected %b, got %b",
                               want.reg_write, rsp.data.reg_write);
                        mismatches++;
                    end
                    if (rsp.data.write_reg !== want.write_reg)
                    begin
                        $error("write_reg: expected %0d, got %0d",
                               want.write_reg, rsp.data.write_reg);
                        mismatches++;
                    end
                    if (rsp.data.write_value !== want.write_value)
                    begin
                        $error("write_value: expected %h, got %h",
                               want.write_value, rsp.data.write_value);
                        mismatches++;
                    end
                    if (rsp.data.status !== want.status)
                    begin
                        $error("status: expected %0d, got %0d",
                               want.status, rsp.data.status);
                        mismatches++;
                    end
                end
            end

            if (cmd.valid && cmd.ready)
                expected_results.push_back(exec_instr(cmd.data));

            // start_pc write also reloads the PC
            if (psel && penable && pwrite && pready && paddr == START_PC_ADDR)
            begin
                start_pc_q = pwdata;
                pc_q       = pwdata;
            end

            pending = expected_results.size();
        end
    end

endmodule

/* tb/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Drives instruction items into the RV32I subset executor: a directed set
// covering every operation and error case, then random programs under
// several start_pc settings, with random idling on both channels except in one calm run, and one
// long result stall. The checker module predicts and compares.
// ----------------------------------------------------------------------------
module tb_top;
    import rvx_pkg::*;

    localparam int         DMEM_WORDS   = 1024;
    localparam logic [2:0] REG_START_PC = 3'd0;
    localparam int         HOLD_CYCLES  = 80;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    int mismatches;
    int pending;

    // calm: no idling on either side; hold_go: one long result stall
    bit calm;
    bit hold_go;
    bit hold_done;
    int hold_cnt;

    rvx_cmd_if cmd_ch ();
    rvx_rsp_if rsp_ch ();

    rv32i_subset_executor #(
        .DMEM_WORDS(DMEM_WORDS)
    ) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd_ch),
        .rsp    (rsp_ch),
        .psel   (psel),
        .penable(penable),
        .pwrite (pwrite),
        .paddr  (paddr),
        .pwdata (pwdata),
        .prdata (prdata),
        .pready (pready)
    );

    rvx_result_checker #(
        .DMEM_WORDS   (DMEM_WORDS),
        .START_PC_ADDR(REG_START_PC)
    ) u_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd_ch),
        .rsp       (rsp_ch),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .pready    (pready),
        .mismatches(mismatches),
        .pending   (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #2000000;
        $display("Verification failed");
        $finish;
    end

    function automatic cmd_t mk(logic [6:0] func, logic [2:0] minor, logic [6:0] variant,
                                logic [4:0] rd, logic [4:0] ra, logic [4:0] rb,
                                logic [31:0] imm);
        cmd_t c;
        c.func        = func;
        c.minor_op    = minor;
        c.variant     = variant;
        c.dest_index  = rd;
        c.src_a_index = ra;
        c.src_b_index = rb;
        c.immediate   = imm;
        return c;
    endfunction

    function automatic cmd_t rand_instr();
        cmd_t        c;
        int          pick;
        int          word;
        logic [31:0] off;
        c = mk(7'($urandom), 3'($urandom), 7'($urandom), 5'($urandom),
               5'($urandom), 5'($urandom), $urandom);
        pick = $urandom_range(99);
        if (pick >= 88)
            return c;  // noise, every field random
        if (pick >= 82)
        begin
            // broken: supported func with a random minor_op
            case ($urandom_range(4))
                0: c.func = FUNC_REG;
                1: c.func = FUNC_IMM;
                2: c.func = FUNC_LOAD;
                3: c.func = FUNC_STORE;
                default: c.func = FUNC_BRANCH;
            endcase
            return c;
        end
        case ($urandom_range(9))
            0, 1, 2:
            begin
                c.func = FUNC_REG;
                case ($urandom_range(3))
                    0: c.minor_op = MINOR_ADD;
                    1: c.minor_op = MINOR_AND;
                    2: c.minor_op = MINOR_OR;
                    default: c.minor_op = MINOR_XOR;
                endcase
                if (c.minor_op == MINOR_ADD && $urandom_range(1))
                    c.variant = VARIANT_SUB;
            end
            3, 4:
            begin
                c.func     = FUNC_IMM;
                c.minor_op = MINOR_ADD;
                if ($urandom_range(2) != 0)
                    c.immediate = $urandom_range(4095) - 2048;
            end
            5, 6:
            begin
                c.func     = ($urandom_range(1)) ? FUNC_LOAD : FUNC_STORE;
                c.minor_op = MINOR_WORD;
                case ($urandom_range(9))
                    0:       word = $urandom_range(DMEM_WORDS + 3, DMEM_WORDS - 4);
                    default: word = $urandom_range(31);
                endcase
                off = 32'(word) << 2;
                if ($urandom_range(9) == 0)
                    off = off + $urandom_range(3, 1);
                if ($urandom_range(9) < 7)
                begin
                    c.src_a_index = 5'd0;
                    c.immediate   = off;
                end
                else
                    c.immediate = $urandom_range(255) - 128;
            end
            7, 8:
            begin
                c.func     = FUNC_BRANCH;
                c.minor_op = MINOR_BEQ;
                if ($urandom_range(9) < 4)
                    c.src_b_index = c.src_a_index;
                if ($urandom_range(3) != 0)
                    c.immediate = ($urandom_range(255) - 128) * 4;
            end
            default:
            begin
                c.func = FUNC_JAL;
                if ($urandom_range(3) != 0)
                    c.immediate = ($urandom_range(255) - 128) * 4;
            end
        endcase
        return c;
    endfunction

    task automatic send_instr(cmd_t c);
        int gap;
        gap = 0;
        if (!calm)
            while ($urandom_range(99) < 34 && gap < 20)
                gap++;
        @(negedge clk);
        if (gap > 0)
        begin
            cmd_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        cmd_ch.valid <= 1'b1;
        cmd_ch.data  <= c;
        do
            @(posedge clk);
        while (!cmd_ch.ready);
    endtask

    task automatic drain();
        @(negedge clk);
        cmd_ch.valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_start_pc(logic [31:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= REG_START_PC;
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic run_random(int count);
        for (int i = 0; i < count; i++)
            send_instr(rand_instr());
        drain();
    endtask

    // result side: random stalls, plus one long hold-off on request
    initial
    begin
        rsp_ch.ready = 1'b0;
        hold_done    = 1'b0;
        hold_cnt     = 0;
        forever
        begin
            @(negedge clk);
            if (hold_go && !hold_done)
            begin
                hold_done = 1'b1;
                hold_cnt  = HOLD_CYCLES;
            end
            if (hold_cnt > 0)
            begin
                rsp_ch.ready <= 1'b0;
                hold_cnt--;
            end
            else if (calm)
                rsp_ch.ready <= 1'b1;
            else
                rsp_ch.ready <= ($urandom_range(99) >= 34);
        end
    end

    initial
    begin
        rst_n        = 1'b0;
        cmd_ch.valid = 1'b0;
        cmd_ch.data  = '0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        calm         = 1'b0;
        hold_go      = 1'b0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        write_start_pc(32'h0000_1000);

        send_instr(mk(FUNC_IMM, MINOR_ADD, 7'h00, 5'd1, 5'd0, 5'd0, 32'h7FFF_FFFF));
        send_instr(mk(FUNC_IMM, MINOR_ADD, 7'h7F, 5'd2, 5'd0, 5'd0, 32'h8000_0000));
        send_instr(mk(FUNC_REG, MINOR_ADD, 7'h00, 5'd3, 5'd1, 5'd2, 32'h0));
        send_instr(mk(FUNC_REG, MINOR_ADD, VARIANT_SUB, 5'd4, 5'd1, 5'd2, 32'h0));
        // any other variant is still ADD
        send_instr(mk(FUNC_REG, MINOR_ADD, 7'h7F, 5'd5, 5'd1, 5'd1, 32'h0));
        send_instr(mk(FUNC_REG, MINOR_AND, 7'h7F, 5'd6, 5'd1, 5'd4, 32'h0));
        send_instr(mk(FUNC_REG, MINOR_OR, VARIANT_SUB, 5'd7, 5'd1, 5'd2, 32'h0));
        send_instr(mk(FUNC_REG, MINOR_XOR, 7'h00, 5'd8, 5'd4, 5'd31, 32'h0));
        send_instr(mk(FUNC_IMM, MINOR_ADD, 7'h00, 5'd9, 5'd0, 5'd0, 32'd64));
        send_instr(mk(FUNC_STORE, MINOR_WORD, 7'h00, 5'd0, 5'd9, 5'd1, 32'd0));
        send_instr(mk(FUNC_LOAD, MINOR_WORD, 7'h00, 5'd10, 5'd0, 5'd0, 32'd64));
        send_instr(mk(FUNC_LOAD, MINOR_WORD, 7'h00, 5'd11, 5'd9, 5'd0, 32'd1));
        send_instr(mk(FUNC_STORE, MINOR_WORD, 7'h00, 5'd0, 5'd0, 5'd1, 32'd66));
        // word index exactly at the memory size, then a wrapped negative address
        send_instr(mk(FUNC_LOAD, MINOR_WORD, 7'h00, 5'd12, 5'd0, 5'd0, 32'(DMEM_WORDS * 4)));
        send_instr(mk(FUNC_STORE, MINOR_WORD, 7'h00, 5'd0, 5'd0, 5'd1, 32'hFFFF_FFFC));
        send_instr(mk(FUNC_LOAD, MINOR_WORD, 7'h00, 5'd0, 5'd0, 5'd0, 32'd64));
        send_instr(mk(FUNC_IMM, MINOR_ADD, 7'h00, 5'd0, 5'd1, 5'd0, 32'd5));
        send_instr(mk(FUNC_BRANCH, MINOR_BEQ, 7'h00, 5'd0, 5'd1, 5'd1, 32'd16));
        send_instr(mk(FUNC_BRANCH, MINOR_BEQ, 7'h00, 5'd0, 5'd1, 5'd2, 32'd100));
        send_instr(mk(FUNC_JAL, 3'd0, 7'h00, 5'd31, 5'd0, 5'd0, 32'hFFFF_FFF8));
        send_instr(mk(FUNC_JAL, 3'd7, 7'h7F, 5'd0, 5'd31, 5'd31, 32'd6));
        send_instr(mk(7'h7F, 3'd0, 7'h00, 5'd13, 5'd1, 5'd2, 32'h0));
        send_instr(mk(FUNC_REG, 3'd1, 7'h00, 5'd14, 5'd1, 5'd2, 32'h0));
        send_instr(mk(FUNC_IMM, 3'd7, 7'h00, 5'd15, 5'd1, 5'd0, 32'h0));
        send_instr(mk(FUNC_LOAD, 3'd0, 7'h00, 5'd16, 5'd0, 5'd0, 32'd64));
        send_instr(mk(FUNC_STORE, 3'd3, 7'h00, 5'd0, 5'd0, 5'd1, 32'd0));
        send_instr(mk(FUNC_BRANCH, 3'd1, 7'h00, 5'd0, 5'd0, 5'd0, 32'd8));
        drain();

        // PC wraps past the top
        write_start_pc(32'hFFFF_FFFC);
        hold_go = 1'b1;
        run_random(150);

        write_start_pc(32'hFFFF_FFFF);
        calm = 1'b1;
        run_random(150);
        calm = 1'b0;

        write_start_pc($urandom);
        run_random(100);

        write_start_pc(32'h0000_0000);
        run_random(100);

        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

/* rv32i_subset_executor.f */
rtl/rvx_pkg.sv
rtl/rvx_if.sv
rtl/rvx_ram.sv
rtl/rv32i_subset_executor.sv
tb/rvx_result_checker.sv
tb/tb_top.sv
